@@ rtl/tcptsp_pkg.sv @@
package tcptsp_pkg;

  // Longest TCP option area: a 60-byte header less the 20-byte fixed part.
  localparam int unsigned MAX_OPTION_BYTES = 40;
  localparam int unsigned LEN_W            = 6;

  localparam logic [7:0] KIND_EOL   = 8'd0;
  localparam logic [7:0] KIND_NOP   = 8'd1;
  localparam logic [7:0] KIND_TS    = 8'd8;
  localparam logic [7:0] TS_OPT_LEN = 8'd10;

  // Number of body bytes in a timestamp option (TSval then TSecr).
  localparam logic [3:0] TS_BODY_BYTES  = 4'd8;
  localparam logic [3:0] TS_VALUE_BYTES = 4'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_FOUND = 2'd0;
  localparam status_t ST_NONE  = 2'd1;
  localparam status_t ST_BAD   = 2'd2;

  typedef enum logic [5:0] {
    PH_KIND      = 6'b000001,
    PH_LEN_OTHER = 6'b000010,
    PH_LEN_TS    = 6'b000100,
    PH_SKIP      = 6'b001000,
    PH_TS        = 6'b010000,
    PH_DONE      = 6'b100000
  } phase_t;

endpackage

@@ rtl/tcp_timestamp_option_parser.sv @@
// TCP timestamp option parser.
//
// The input channel carries one byte of a segment's TCP option area per
// request, in wire order. The request that carries in_first also carries
// in_area_len, the option area length (saturated at 40). The request that
// carries in_last produces exactly one result request on the out_ channel:
// a status (found, none, malformed) and the TSval and TSecr fields, which
// are zero unless the timestamp option was found.
//
// Each byte is parsed in the cycle it is accepted; the parse state is
// updated at that edge and, on a last byte, the result register is loaded
// at the same edge, so out_valid rises in the cycle after the last byte.
// Throughput is one byte per cycle while in_ready is high.
//
// The result register acts as the output stage, and in_ready is
// !out_valid | out_ready. While a result waits and the receiver stalls, no
// byte is accepted, so the waiting result is never overwritten; when the
// receiver takes the result, a new byte is accepted in the same cycle.
// Reset (rst_n low, synchronous) clears the parse state to "expect option
// kind" with no area left, and drops out_valid.
module tcp_timestamp_option_parser
  import tcptsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_opt_byte,
  input  logic        in_first,
  input  logic [5:0]  in_area_len,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_ts_value,
  output logic [31:0] out_ts_echo
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_OPTION_BYTES);

  // Parse state.
  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [LEN_W-1:0]  skip_r, skip_nxt;
  logic [3:0]        cidx_r, cidx_nxt;
  logic [31:0]       value_r, value_nxt;
  logic [31:0]       echo_r, echo_nxt;
  status_t           outcome_r, outcome_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [31:0]       out_ts_value_r;
  logic [31:0]       out_ts_echo_r;

  // State as seen by the byte after a possible first-byte clear.
  phase_t            ph_cur;
  logic [LEN_W-1:0]  bl_cur;
  logic [LEN_W-1:0]  skip_cur;
  logic [3:0]        cidx_cur;
  logic [31:0]       value_cur;
  logic [31:0]       echo_cur;
  status_t           outcome_cur;

  logic              accept;
  logic [6:0]        room;
  logic [LEN_W-1:0]  skip_dec;
  logic [3:0]        cidx_inc;
  status_t           res_status;
  logic [31:0]       res_value;
  logic [31:0]       res_echo;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ph_cur      = phase_r;
    bl_cur      = bytes_left_r;
    skip_cur    = skip_r;
    cidx_cur    = cidx_r;
    value_cur   = value_r;
    echo_cur    = echo_r;
    outcome_cur = outcome_r;
    if (in_first) begin
      ph_cur      = PH_KIND;
      bl_cur      = (in_area_len > MAX_LEN) ? MAX_LEN : in_area_len;
      skip_cur    = '0;
      cidx_cur    = '0;
      value_cur   = '0;
      echo_cur    = '0;
      outcome_cur = ST_NONE;
    end
  end

  // A length byte may span the remaining area plus the kind byte before it.
  assign room     = {1'b0, bl_cur} + 7'd1;
  assign skip_dec = skip_cur - LEN_W'(1);
  assign cidx_inc = cidx_cur + 4'd1;

  always_comb begin
    phase_nxt      = ph_cur;
    bytes_left_nxt = bl_cur;
    skip_nxt       = skip_cur;
    cidx_nxt       = cidx_cur;
    value_nxt      = value_cur;
    echo_nxt       = echo_cur;
    outcome_nxt    = outcome_cur;

    if (bl_cur != '0) begin
      bytes_left_nxt = bl_cur - LEN_W'(1);
      case (ph_cur)
        PH_KIND: begin
          if (in_opt_byte == KIND_EOL) begin
            outcome_nxt = ST_NONE;
            phase_nxt   = PH_DONE;
          end else if (in_opt_byte == KIND_NOP) begin
            phase_nxt = PH_KIND;
          end else if (bl_cur < LEN_W'(2)) begin
            outcome_nxt = ST_BAD;
            phase_nxt   = PH_DONE;
          end else begin
            phase_nxt = (in_opt_byte == KIND_TS) ? PH_LEN_TS : PH_LEN_OTHER;
          end
        end
        PH_LEN_OTHER, PH_LEN_TS: begin
          if (in_opt_byte < 8'd2 || in_opt_byte > {1'b0, room}) begin
            outcome_nxt = ST_BAD;
            phase_nxt   = PH_DONE;
          end else if (ph_cur == PH_LEN_TS) begin
            if (in_opt_byte != TS_OPT_LEN) begin
              outcome_nxt = ST_BAD;
              phase_nxt   = PH_DONE;
            end else begin
              cidx_nxt  = '0;
              value_nxt = '0;
              echo_nxt  = '0;
              phase_nxt = PH_TS;
            end
          end else begin
            // The length is at most 41 here, so its low bits suffice.
            skip_nxt  = in_opt_byte[LEN_W-1:0] - LEN_W'(2);
            phase_nxt = (in_opt_byte == 8'd2) ? PH_KIND : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = PH_KIND;
          end
        end
        PH_TS: begin
          if (cidx_cur < TS_VALUE_BYTES) begin
            value_nxt = {value_cur[23:0], in_opt_byte};
          end else begin
            echo_nxt = {echo_cur[23:0], in_opt_byte};
          end
          cidx_nxt = cidx_inc;
          if (cidx_inc >= TS_BODY_BYTES) begin
            outcome_nxt = ST_FOUND;
            phase_nxt   = PH_DONE;
          end
        end
        default: begin
          // Decision made: remaining bytes are only counted off.
        end
      endcase
    end

    // The status reflects the state after this byte has been parsed.
    case (phase_nxt)
      PH_DONE: res_status = outcome_nxt;
      PH_KIND: res_status = ST_NONE;
      default: res_status = ST_BAD;
    endcase

    // On a found result the values are those after this byte's parse step.
    res_value = (res_status == ST_FOUND) ? value_nxt : '0;
    res_echo  = (res_status == ST_FOUND) ? echo_nxt : '0;

    // A last byte closes the area and returns the parser to idle.
    if (in_last) begin
      phase_nxt      = PH_KIND;
      bytes_left_nxt = '0;
      skip_nxt       = '0;
      cidx_nxt       = '0;
      value_nxt      = '0;
      echo_nxt       = '0;
      outcome_nxt    = ST_NONE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && in_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_KIND;
      bytes_left_r <= '0;
      skip_r       <= '0;
      cidx_r       <= '0;
      value_r      <= '0;
      echo_r       <= '0;
      outcome_r    <= ST_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r      <= phase_nxt;
        bytes_left_r <= bytes_left_nxt;
        skip_r       <= skip_nxt;
        cidx_r       <= cidx_nxt;
        value_r      <= value_nxt;
        echo_r       <= echo_nxt;
        outcome_r    <= outcome_nxt;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid.
  always_ff @(posedge clk) begin
    if (accept && in_last) begin
      out_status_r   <= res_status;
      out_ts_value_r <= res_value;
      out_ts_echo_r  <= res_echo;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_ts_value = out_ts_value_r;
  assign out_ts_echo  = out_ts_echo_r;

  // A last byte always yields a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> out_valid_r)
    else $error("last byte did not produce a result");

  // Only a found result carries nonzero timestamp fields.
  a_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_FOUND |-> out_ts_value_r == '0 && out_ts_echo_r == '0)
    else $error("timestamp fields set on a result that is not found");

  // The remaining area never exceeds the longest option area.
  a_area_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r <= MAX_LEN)
    else $error("bytes left above the option area limit");

  // While skipping, there is always at least one body byte still to skip.
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != '0)
    else $error("skip phase with nothing left to skip");

  // Capture never runs past the eight timestamp body bytes.
  a_capture_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TS |-> cidx_r < TS_BODY_BYTES)
    else $error("timestamp capture index out of range");

endmodule

@@ tb/tb.sv @@
module tb;
  import tcptsp_pkg::*;

  // The watchdog ends the run after this many cycles in which neither
  // channel moves a request. The longest correct quiet stretch is a
  // sender gap plus a receiver stall.
  localparam int unsigned QUIET_LIMIT = 2000;

  // One expected result request: status plus TSval and TSecr.
  typedef struct packed {
    status_t     status;
    logic [31:0] tsval;
    logic [31:0] tsecr;
  } ts_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_opt_byte = 8'd0;
  logic        in_first = 1'b0;
  logic [5:0]  in_area_len = 6'd0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_ts_value;
  logic [31:0] out_ts_echo;

  // Results that the parser owes us, oldest first.
  ts_result_t expected_ts_results[$];

  // Our own copy of the option walk. It is updated once per accepted
  // request, in the same order in which the block sees the bytes.
  phase_t      parse_ph;
  logic [5:0]  area_left;
  logic [5:0]  skip_left;
  logic [3:0]  ts_byte_idx;
  logic [31:0] tsval_acc;
  logic [31:0] tsecr_acc;
  status_t     parse_verdict;

  // Option area bytes of the segment being built by a random test.
  logic [7:0] seg_bytes[$];

  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ready_run = 0;
  int unsigned stall_limit = 4;

  tcp_timestamp_option_parser DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opt_byte  (in_opt_byte),
    .in_first     (in_first),
    .in_area_len  (in_area_len),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_ts_value (out_ts_value),
    .out_ts_echo  (out_ts_echo)
  );

  always #6 clk = ~clk;

  // Back to the idle state: expect an option kind, nothing found yet.
  function automatic void clear_parse();
    parse_ph      = PH_KIND;
    area_left     = '0;
    skip_left     = '0;
    ts_byte_idx   = '0;
    tsval_acc     = '0;
    tsecr_acc     = '0;
    parse_verdict = ST_NONE;
  endfunction

  // Advances the option walk by one byte and, on a last byte, queues the
  // result that the parser must produce. A first byte restarts the walk
  // with the area length saturated at the largest legal option area.
  function automatic void parse_option_byte(input logic [7:0] b, input logic is_first,
                                            input logic [5:0] alen, input logic is_last);
    ts_result_t r;
    if (is_first) begin
      clear_parse();
      area_left = (alen > MAX_OPTION_BYTES) ? 6'(MAX_OPTION_BYTES) : alen;
    end
    // Bytes past the end of the area and bytes after a decision are
    // ignored; area_left still counts down inside the area.
    if (area_left != 0) begin
      case (parse_ph)
        PH_KIND: begin
          if (b == KIND_EOL) begin
            parse_verdict = ST_NONE;
            parse_ph = PH_DONE;
          end else if (b == KIND_NOP) begin
            parse_ph = PH_KIND;
          end else if (area_left < 6'd2) begin
            // A real option needs at least its kind and length bytes.
            parse_verdict = ST_BAD;
            parse_ph = PH_DONE;
          end else if (b == KIND_TS) begin
            parse_ph = PH_LEN_TS;
          end else begin
            parse_ph = PH_LEN_OTHER;
          end
        end
        PH_LEN_OTHER, PH_LEN_TS: begin
          // The kind byte was one earlier, so the option may span one byte
          // more than what is left from here.
          if (b < 8'd2 || int'(b) > int'(area_left) + 1) begin
            parse_verdict = ST_BAD;
            parse_ph = PH_DONE;
          end else if (parse_ph == PH_LEN_TS) begin
            if (b != TS_OPT_LEN) begin
              parse_verdict = ST_BAD;
              parse_ph = PH_DONE;
            end else begin
              ts_byte_idx = '0;
              tsval_acc = '0;
              tsecr_acc = '0;
              parse_ph = PH_TS;
            end
          end else begin
            skip_left = 6'(b - 8'd2);
            parse_ph = (skip_left == 0) ? PH_KIND : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_left = skip_left - 6'd1;
          if (skip_left == 0) parse_ph = PH_KIND;
        end
        PH_TS: begin
          // TSval comes first, then TSecr, both most significant byte first.
          if (ts_byte_idx < TS_VALUE_BYTES) tsval_acc = {tsval_acc[23:0], b};
          else tsecr_acc = {tsecr_acc[23:0], b};
          ts_byte_idx = ts_byte_idx + 4'd1;
          if (ts_byte_idx >= TS_BODY_BYTES) begin
            parse_verdict = ST_FOUND;
            parse_ph = PH_DONE;
          end
        end
        default: begin
        end
      endcase
      area_left = area_left - 6'd1;
    end
    if (is_last) begin
      // A walk stopped in the middle of an option is malformed.
      if (parse_ph == PH_DONE) r.status = parse_verdict;
      else if (parse_ph == PH_KIND) r.status = ST_NONE;
      else r.status = ST_BAD;
      r.tsval = (r.status == ST_FOUND) ? tsval_acc : '0;
      r.tsecr = (r.status == ST_FOUND) ? tsecr_acc : '0;
      expected_ts_results.push_back(r);
      clear_parse();
    end
  endfunction

  // Sends one option byte as a request and waits until it is taken. The
  // handshake is read at the falling edge, where in_ready already holds
  // the value it has at the next rising edge. After the request the
  // sender may pause, in bursts of random length.
  task automatic send_option_byte(input logic [7:0] b, input logic is_first,
                                  input logic [5:0] alen, input logic is_last);
    bit taken;
    in_valid    <= 1'b1;
    in_opt_byte <= b;
    in_first    <= is_first;
    in_area_len <= alen;
    in_last     <= is_last;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    parse_option_byte(b, is_first, alen, is_last);
    bytes_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 23);
      if ($urandom_range(0, 4) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  endtask

  // Holds the sender off until every owed result has come back. Always
  // waits on the clock before checking, so in_valid is never driven
  // twice in the same step.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_ts_results.size() != 0);
  endtask

  // Builds a well-formed option area: NOPs, timestamp options, other
  // options skipped by length, and now and then end-of-list followed by
  // padding. Mostly word-aligned lengths, as real headers have.
  task automatic build_wellformed(output logic [5:0] alen);
    int unsigned len;
    int unsigned room;
    int unsigned olen;
    logic [7:0]  kind;
    seg_bytes.delete();
    if ($urandom_range(0, 3) == 0) len = $urandom_range(0, MAX_OPTION_BYTES);
    else len = 4 * $urandom_range(0, MAX_OPTION_BYTES / 4);
    while (seg_bytes.size() < len) begin
      room = len - seg_bytes.size();
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          if (room >= 10) begin
            seg_bytes.push_back(KIND_TS);
            seg_bytes.push_back(TS_OPT_LEN);
            repeat (8) seg_bytes.push_back(8'($urandom));
          end else begin
            seg_bytes.push_back(KIND_NOP);
          end
        end
        3, 4: begin
          if (room >= 2) begin
            kind = 8'($urandom_range(2, 255));
            if (kind == KIND_TS) kind = 8'd3;
            olen = $urandom_range(2, (room < 12) ? room : 12);
            seg_bytes.push_back(kind);
            seg_bytes.push_back(8'(olen));
            repeat (olen - 2) seg_bytes.push_back(8'($urandom));
          end else begin
            seg_bytes.push_back(KIND_NOP);
          end
        end
        5: begin
          seg_bytes.push_back(KIND_EOL);
          while (seg_bytes.size() < len) seg_bytes.push_back(8'($urandom));
        end
        default: begin
          seg_bytes.push_back(KIND_NOP);
        end
      endcase
    end
    // An empty area still needs one request to carry first and last.
    if (len == 0) seg_bytes.push_back(8'($urandom));
    alen = 6'(len);
    if (len == MAX_OPTION_BYTES && $urandom_range(0, 1) == 0) alen = 6'($urandom_range(41, 63));
  endtask

  // Directed segments: field extremes and each corner of the walk.
  task automatic test_edge_cases();
    // Empty area, with first and last on the same byte.
    send_option_byte(8'hFF, 1'b1, 6'd0, 1'b1);
    // Oversized area length saturates; end-of-list right away.
    send_option_byte(KIND_EOL, 1'b1, 6'd63, 1'b1);
    // A kind byte with only itself left in the area is malformed.
    send_option_byte(8'hFF, 1'b1, 6'd1, 1'b1);
    // NOP then a timestamp whose TSval and TSecr each alternate all-ones and
    // all-zeros bytes, then one byte past the end of the area, which is ignored.
    send_option_byte(KIND_NOP, 1'b1, 6'd11, 1'b0);
    send_option_byte(KIND_TS, 1'b0, 6'h3F, 1'b0);
    send_option_byte(TS_OPT_LEN, 1'b0, 6'h00, 1'b0);
    for (int i = 0; i < 8; i++)
      send_option_byte(((i % 2 == 0) ^ (i >= 4)) ? 8'hFF : 8'h00, 1'b0, 6'h3F, 1'b0);
    send_option_byte(8'h5A, 1'b0, 6'h2A, 1'b1);
    // Length below two, then a timestamp kind that comes after the
    // decision and must not change it.
    send_option_byte(8'h05, 1'b1, 6'd4, 1'b0);
    send_option_byte(8'h01, 1'b0, 6'h15, 1'b0);
    send_option_byte(KIND_TS, 1'b0, 6'h3F, 1'b1);
    // Timestamp option with a length other than ten that still fits the area.
    send_option_byte(KIND_TS, 1'b1, 6'd12, 1'b0);
    send_option_byte(8'd9, 1'b0, 6'h00, 1'b1);
    // Option length that runs past the end of the area.
    send_option_byte(8'h1E, 1'b1, 6'd3, 1'b0);
    send_option_byte(8'd5, 1'b0, 6'h00, 1'b1);
    // The feeder stops in the middle of an option.
    send_option_byte(8'h02, 1'b1, 6'd8, 1'b0);
    send_option_byte(8'h04, 1'b0, 6'h00, 1'b1);
    // A stray last byte with no first mark reports no timestamp.
    send_option_byte(8'h77, 1'b0, 6'h2A, 1'b1);
  endtask

  // Random well-formed segments, each ending with a last byte.
  task automatic test_wellformed_segments(input int unsigned target);
    logic [5:0] alen;
    while (bytes_sent < target) begin
      build_wellformed(alen);
      for (int i = 0; i < seg_bytes.size(); i++)
        send_option_byte(seg_bytes[i], i == 0, (i == 0) ? alen : 6'($urandom),
                         i == seg_bytes.size() - 1);
    end
  endtask

  // Random segments biased toward interesting byte values, with random
  // area lengths, missing or early last marks, first marks in the middle
  // and short runs of stray bytes.
  task automatic test_broken_segments(input int unsigned target);
    int unsigned n;
    bit          stray;
    logic [5:0]  alen;
    logic [7:0]  b;
    while (bytes_sent < target) begin
      stray = ($urandom_range(0, 7) == 0);
      n = stray ? $urandom_range(1, 4) : $urandom_range(1, 44);
      alen = ($urandom_range(0, 1) == 0) ? 6'(n) : 6'($urandom);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 5))
          0: b = KIND_NOP;
          1: b = KIND_TS;
          2: b = TS_OPT_LEN;
          3: b = 8'($urandom_range(0, 12));
          default: b = 8'($urandom);
        endcase
        send_option_byte(b, !stray && (i == 0 || $urandom_range(0, 29) == 0),
                         (i == 0) ? alen : 6'($urandom),
                         (i == n - 1) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 39) == 0));
      end
    end
  endtask

  // The receiver alternates ready runs and stalls of random length, and
  // now and then switches to a stall-free stretch or a new stall depth.
  always @(posedge clk) begin
    if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else if (out_ready && stall_limit != 0) begin
      out_ready <= 1'b0;
      ready_run <= $urandom_range(0, stall_limit - 1);
    end else begin
      out_ready <= 1'b1;
      ready_run <= $urandom_range(0, 15);
      if ($urandom_range(0, 9) == 0)
        stall_limit <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end
  end

  // Every result request taken is compared with the oldest expectation.
  always @(posedge clk) begin
    ts_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_ts_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d value %h echo %h",
                 $time, out_status, out_ts_value, out_ts_echo);
        error_count++;
      end else begin
        want = expected_ts_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_ts_value !== want.tsval) begin
          $display("%0t: TSval expected %h, actual %h", $time, want.tsval, out_ts_value);
          error_count++;
        end
        if (out_ts_echo !== want.tsecr) begin
          $display("%0t: TSecr expected %h, actual %h", $time, want.tsecr, out_ts_echo);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL tcp_timestamp_option_parser");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_parse();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_edge_cases();
    // Let the parser drain completely at least once before moving on.
    wait_for_results();
    test_wellformed_segments(800);
    wait_for_results();
    test_broken_segments(1200);
    wait_for_results();
    // A final wait catches any result that nobody asked for.
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS tcp_timestamp_option_parser");
    end else begin
      $display("FAIL tcp_timestamp_option_parser");
    end
    $finish;
  end

endmodule
